[rtl/smpq_pkg.sv]
package smpq_pkg;

  // Default sizes
  localparam int DEPTH_DEF       = 512;
  localparam int KEY_BITS_DEF    = 32;
  localparam int HANDLE_BITS_DEF = 9;

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_GET    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } smpq_status_t;

  // Store write selection
  typedef enum logic [1:0] {
    WR_NONE,
    WR_SHIFT,
    WR_NEW_UP,
    WR_NEW_ZERO
  } smpq_wr_op_t;

  // Controller to datapath
  typedef struct packed {
    logic         take;
    logic         rd_en;
    smpq_wr_op_t  wr_op;
    logic         cnt_inc;
    logic         cnt_dec;
    logic         load_out;
    logic         from_mem;
    smpq_status_t res_status;
  } smpq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic stays;
    logic bottom;
  } smpq_sts_t;

endpackage

[rtl/smpq_datapath.sv]
module smpq_datapath import smpq_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  smpq_cmd_t              cmd,
  output smpq_sts_t              sts,
  input  logic [KEY_BITS-1:0]    key_in,
  input  logic [HANDLE_BITS-1:0] handle_in,
  output logic [1:0]             status,
  output logic [KEY_BITS-1:0]    key_out,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [CW-1:0]          occupancy
);

  // Entries are held with the head at the top slot (count-1), so a get
  // reads one slot and an insert moves only the entries ahead of it.
  logic [KEY_BITS-1:0]    mem_key    [DEPTH];
  logic [HANDLE_BITS-1:0] mem_handle [DEPTH];

  logic [CW-1:0]          count;
  logic [CW-1:0]          last_idx;
  logic [KEY_BITS-1:0]    new_key;
  logic [HANDLE_BITS-1:0] new_handle;
  logic [KEY_BITS-1:0]    rd_key;
  logic [HANDLE_BITS-1:0] rd_handle;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          data_addr;
  logic [AW-1:0]          up_addr;
  logic                   is_head;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_BITS-1:0]    wr_key;
  logic [HANDLE_BITS-1:0] wr_handle;

  assign last_idx = count - CW'(1);
  assign up_addr  = data_addr + AW'(1);
  assign is_head  = (CW'(data_addr) == last_idx);

  // Status for the controller
  assign sts.empty  = (count == '0);
  assign sts.full   = (count == CW'(DEPTH));
  assign sts.bottom = (data_addr == '0);
  // Head keeps its place on an equal key; later entries only when strictly smaller
  assign sts.stays  = is_head ? (new_key >= rd_key) : (rd_key < new_key);

  // Select the store write
  always_comb begin
    wr_en     = 1'b1;
    wr_addr   = up_addr;
    wr_key    = rd_key;
    wr_handle = rd_handle;
    unique case (cmd.wr_op)
      WR_NONE: begin
        wr_en = 1'b0;
      end
      WR_SHIFT: begin
        wr_addr = up_addr;
      end
      WR_NEW_UP: begin
        wr_key    = new_key;
        wr_handle = new_handle;
      end
      WR_NEW_ZERO: begin
        wr_addr   = '0;
        wr_key    = new_key;
        wr_handle = new_handle;
      end
    endcase
  end

  // Store: one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[wr_addr]    <= wr_key;
      mem_handle[wr_addr] <= wr_handle;
    end
    if (cmd.rd_en) begin
      rd_key    <= mem_key[rd_addr];
      rd_handle <= mem_handle[rd_addr];
    end
  end

  // Hold the item and walk the read pointer down from the head
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      new_key    <= key_in;
      new_handle <= handle_in;
      rd_addr    <= last_idx[AW-1:0];
    end else if (cmd.rd_en) begin
      rd_addr <= rd_addr - AW'(1);
    end
    if (cmd.rd_en) begin
      data_addr <= rd_addr;
    end
  end

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CW'(1);
    end
  end

  // Result word
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status     <= cmd.res_status;
      key_out    <= cmd.from_mem ? rd_key : '0;
      handle_out <= cmd.from_mem ? rd_handle : '0;
      occupancy  <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_inc |-> !sts.full)
    else $error("insert committed on a full queue");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_dec |-> !sts.empty)
    else $error("get committed on an empty queue");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_op == WR_SHIFT || cmd.wr_op == WR_NEW_UP) |->
      (CW'(data_addr) < count && !sts.full))
    else $error("entry moved beyond the occupied slots");

endmodule

[rtl/smpq_ctrl.sv]
module smpq_ctrl import smpq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      req_type,
  output logic      out_valid,
  input  logic      out_stall,
  input  smpq_sts_t sts,
  output smpq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_FIRST,
    S_SCAN,
    S_PLACE,
    S_GET_RD,
    S_FINISH
  } state_t;

  state_t       state;
  smpq_status_t res_status;
  logic         res_from_mem;
  logic         in_fire;
  logic         out_free;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Commands for the datapath
  always_comb begin
    cmd.take       = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.wr_op      = WR_NONE;
    cmd.cnt_inc    = 1'b0;
    cmd.cnt_dec    = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.from_mem   = res_from_mem;
    cmd.res_status = res_status;
    unique case (state)
      S_IDLE: begin
        cmd.take = in_fire;
      end
      S_SCAN_FIRST: begin
        cmd.rd_en = 1'b1;
      end
      S_SCAN: begin
        if (sts.stays) begin
          cmd.wr_op = WR_SHIFT;
          cmd.rd_en = !sts.bottom;
        end else begin
          cmd.wr_op   = WR_NEW_UP;
          cmd.cnt_inc = 1'b1;
        end
      end
      S_PLACE: begin
        cmd.wr_op   = WR_NEW_ZERO;
        cmd.cnt_inc = 1'b1;
      end
      S_GET_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.cnt_dec = 1'b1;
      end
      S_FINISH: begin
        cmd.load_out = out_free;
      end
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      res_status   <= STAT_OK;
      res_from_mem <= 1'b0;
    end else begin
      // Hold the result word until it is taken
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            res_status   <= STAT_OK;
            res_from_mem <= 1'b0;
            if (req_type == REQ_INSERT) begin
              if (sts.full) begin
                res_status <= STAT_FULL;
                state      <= S_FINISH;
              end else if (sts.empty) begin
                state <= S_PLACE;
              end else begin
                state <= S_SCAN_FIRST;
              end
            end else begin
              if (sts.empty) begin
                res_status <= STAT_EMPTY;
                state      <= S_FINISH;
              end else begin
                res_from_mem <= 1'b1;
                state        <= S_GET_RD;
              end
            end
          end
        end
        S_SCAN_FIRST: begin
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (!sts.stays) begin
            state <= S_FINISH;
          end else if (sts.bottom) begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          state <= S_FINISH;
        end
        S_GET_RD: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[rtl/sorted_min_priority_queue_core.sv]
// Channel  Handshake            Word
// -------  -------------------  -------------------------------------------
// in       in_valid / in_stall  req_type, key_in, handle_in
// out      out_valid / out_stall status, key_out, handle_out, occupancy
//
// One item at a time. A get: accept, store read, result. An insert moves each
// entry that sorts ahead of the new one up a slot, one entry a cycle through
// the store's single write port, then writes the new one (slot zero on an
// empty queue). A refused insert or a get on an empty queue: accept, result.
// Synchronous active-high reset empties the queue; the store keeps no reset.
// A result waiting on out_stall does not block the next accept; the item
// after it holds in its last cycle until the output register frees.
module sorted_min_priority_queue_core import smpq_pkg::*; #(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   req_type,
  input  logic [KEY_BITS-1:0]    key_in,
  input  logic [HANDLE_BITS-1:0] handle_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             status,
  output logic [KEY_BITS-1:0]    key_out,
  output logic [HANDLE_BITS-1:0] handle_out,
  output logic [CW-1:0]          occupancy
);

  smpq_cmd_t cmd;
  smpq_sts_t sts;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  smpq_datapath #(
    .DEPTH       (DEPTH),
    .KEY_BITS    (KEY_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .key_in     (key_in),
    .handle_in  (handle_in),
    .status     (status),
    .key_out    (key_out),
    .handle_out (handle_out),
    .occupancy  (occupancy)
  );

endmodule
